/* hw/rtl/ghhd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghhd_pkg - shared types and constants of the heading-hold drive controller
// Widths, codes, reset values and small helper functions.
// ----------------------------------------------------------------------------
package ghhd_pkg;

  // Largest duty that any pin may carry
  localparam int PWM_MAX = 255;

  localparam int ACC_W      = 48;  // heading accumulator, deg Q18
  localparam int HDG_W      = ACC_W - 10;  // heading in deg Q8
  localparam int ELAP_W     = 21;
  localparam int TGT_W      = 17;
  localparam int DUR_W      = 20;
  localparam int GYRO_W     = 18;
  localparam int RATE_W     = GYRO_W + 1;  // rate minus offset
  localparam int DT_W       = 16;
  localparam int GAIN_W     = 8;
  localparam int MARGIN_W   = 12;
  localparam int ANG_W      = 23;  // saturated angle operand
  localparam int ANGF_W     = HDG_W + 2;  // full-width angle
  localparam int MULB_W     = DT_W + 1;
  localparam int PROD_W     = ANG_W + MULB_W;
  localparam int DUTY_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Beyond this magnitude any nonzero gain saturates the duty anyway
  localparam logic signed [ANG_W-1:0] ANG_LIM = ANG_W'(2**21);

  localparam logic [GAIN_W-1:0]   KP_FWD_RST     = 8'd144;
  localparam logic [GAIN_W-1:0]   KP_BACK_RST    = 8'd80;
  localparam logic [GAIN_W-1:0]   KP_TURN_RST    = 8'd48;
  localparam logic [7:0]          BASE_LEFT_RST  = 8'd165;
  localparam logic [7:0]          BASE_RIGHT_RST = 8'd240;
  localparam logic [7:0]          TURN_MIN_RST   = 8'd140;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 12'd512;

  typedef enum logic [0:0] {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MOVE_FWD   = 2'd0,
    MOVE_BACK  = 2'd1,
    MOVE_RIGHT = 2'd2,
    MOVE_LEFT  = 2'd3
  } move_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_FWD     = 3'd0,
    CFG_KP_BACK    = 3'd1,
    CFG_KP_TURN    = 3'd2,
    CFG_BASE_LEFT  = 3'd3,
    CFG_BASE_RIGHT = 3'd4,
    CFG_TURN_MIN   = 3'd5,
    CFG_MARGIN     = 3'd6,
    CFG_GYRO_OFF   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_ACCUM,
    ST_MUL_GAIN,
    ST_RESULT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic mul_gain;  // multiplier takes gain * angle, else rate * dt
    logic acc_en;    // update heading and elapsed time
    logic res_en;    // load the result word
  } ctl_t;

  // Clamp to lo..PWM_MAX and keep the low eight bits
  function automatic logic [7:0] clamp_duty(input logic signed [DUTY_W-1:0] v,
                                            input logic [7:0] lo);
    logic signed [DUTY_W-1:0] lo_s;
    logic signed [DUTY_W-1:0] hi_s;
    logic signed [DUTY_W-1:0] r;
    lo_s = $signed({{(DUTY_W-8){1'b0}}, lo});
    hi_s = DUTY_W'(PWM_MAX);
    if (v < lo_s) begin
      r = lo_s;
    end else if (v > hi_s) begin
      r = hi_s;
    end else begin
      r = v;
    end
    return r[7:0];
  endfunction

endpackage : ghhd_pkg
`default_nettype wire

/* hw/rtl/ghhd_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghhd_mul - shared signed multiplier
// Picks rate * dt or angle * gain and registers the product.
// ----------------------------------------------------------------------------
module ghhd_mul
  import ghhd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     sel_gain,
  input  wire logic signed [RATE_W-1:0] rate,
  input  wire logic        [DT_W-1:0]   dt,
  input  wire logic signed [ANG_W-1:0]  angle,
  input  wire logic        [GAIN_W-1:0] gain,
  output logic signed      [PROD_W-1:0] prod_r
);

  logic signed [ANG_W-1:0]  op_a;
  logic signed [MULB_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod_nxt;

  always_comb begin
    if (sel_gain) begin
      op_a = angle;
      op_b = $signed({{(MULB_W-GAIN_W){1'b0}}, gain});
    end else begin
      op_a = ANG_W'(rate);
      op_b = $signed({1'b0, dt});
    end
    prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule : ghhd_mul
`default_nettype wire

/* hw/rtl/ghhd_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ghhd_seq - sample sequencer
// Steps one sample through multiply, accumulate, multiply and result.
// ----------------------------------------------------------------------------
module ghhd_seq
  import ghhd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic calc_req,  // accepted word needs the arithmetic path
  input  wire logic out_ready,
  output ctl_t      ctl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = calc_req ? ST_MUL_RATE : ST_OUT;
        end
      end
      ST_MUL_RATE: state_nxt = ST_ACCUM;
      ST_ACCUM:    state_nxt = ST_MUL_GAIN;
      ST_MUL_GAIN: state_nxt = ST_RESULT;
      ST_RESULT:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE:     ctl.in_ready  = 1'b1;
      ST_MUL_RATE: ctl.mul_gain  = 1'b0;
      ST_ACCUM:    ctl.acc_en    = 1'b1;
      ST_MUL_GAIN: ctl.mul_gain  = 1'b1;
      ST_RESULT:   ctl.res_en    = 1'b1;
      ST_OUT:      ctl.out_valid = 1'b1;
      default:     ctl = '0;
    endcase
  end

endmodule : ghhd_seq
`default_nettype wire

/* hw/rtl/gyro_heading_hold_drive_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_heading_hold_drive_top - gyro heading-hold drive controller
// Integrates yaw rate into a heading and drives two wheels: straight moves
// steer with a proportional correction, turns run until within a margin.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+--------------------------------
//  in_     | input     | in_valid / in_ready   | cmd, move, target, duration,
//          |           |                       | gyro rate, dt
//  out_    | output    | out_valid / out_ready | four pin duties, move_done
//  cfg_    | input     | cfg_valid / cfg_ready | register index, data
//
//  A start word or a sample after the move has finished is accepted in IDLE
//  and presented from OUT directly. A live sample steps through MUL_RATE,
//  ACCUM, MUL_GAIN and RESULT before OUT: the single shared multiplier runs
//  twice (rate * dt, then gain * angle) with an accumulate step and a result
//  step around it. Input is refused from accept until the result word is
//  taken; a stalled out_ready holds the result word. Reset is synchronous,
//  active low. The configuration port is always ready; a valid word writes.
//
module gyro_heading_hold_drive_top
  import ghhd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [1:0]            in_move_kind,
  input  wire logic [TGT_W-1:0]      in_target_deg,
  input  wire logic [DUR_W-1:0]      in_duration_ticks,
  input  wire logic signed [GYRO_W-1:0] in_gyro_rate,
  input  wire logic [DT_W-1:0]       in_dt_ticks,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_left_a_pwm,
  output logic [7:0]                 out_left_b_pwm,
  output logic [7:0]                 out_right_a_pwm,
  output logic [7:0]                 out_right_b_pwm,
  output logic                       out_move_done,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [GAIN_W-1:0]          kp_fwd_r, kp_back_r, kp_turn_r;
  logic [7:0]                 base_left_r, base_right_r, turn_min_r;
  logic [MARGIN_W-1:0]        margin_r;
  logic signed [GYRO_W-1:0]   gyro_off_r;

  // Move state
  logic signed [ACC_W-1:0]    heading_accum_r;
  logic [ELAP_W-1:0]          elapsed_r;
  move_t                      active_move_r;
  logic [TGT_W-1:0]           turn_target_r;
  logic [DUR_W-1:0]           move_duration_r;
  logic                       finished_r;

  // Operands held for the sample
  logic signed [RATE_W-1:0]   rate_r;
  logic [DT_W-1:0]            dt_r;

  logic [7:0]                 la_r, lb_r, ra_r, rb_r;
  logic                       done_r;

  ctl_t                       ctl;
  logic                       in_fire;
  logic                       calc_req;
  logic signed [PROD_W-1:0]   prod_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctl.in_ready;
  assign out_valid = ctl.out_valid;
  assign in_fire   = in_valid & ctl.in_ready;
  assign calc_req  = (in_cmd == CMD_SAMPLE) & ~finished_r;

  assign out_left_a_pwm  = la_r;
  assign out_left_b_pwm  = lb_r;
  assign out_right_a_pwm = ra_r;
  assign out_right_b_pwm = rb_r;
  assign out_move_done   = done_r;

  ghhd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .calc_req  (calc_req),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // --------------------------------------------------------------------------
  // Angle and gain for the second multiply; also drives the turn stop test
  // --------------------------------------------------------------------------
  logic signed [HDG_W-1:0]    h_q8;
  logic signed [ANGF_W-1:0]   h_ext;
  logic signed [ANGF_W-1:0]   tgt_ext;
  logic signed [ANGF_W-1:0]   angle_full;
  logic signed [ANG_W-1:0]    angle_sat;
  logic [GAIN_W-1:0]          gain_sel;

  // Floor divide by 1024 is an arithmetic shift
  assign h_q8    = heading_accum_r[ACC_W-1:10];
  assign h_ext   = ANGF_W'(h_q8);
  assign tgt_ext = $signed({{(ANGF_W-TGT_W){1'b0}}, turn_target_r});

  always_comb begin
    unique case (active_move_r)
      MOVE_FWD: begin
        angle_full = -h_ext;
        gain_sel   = kp_fwd_r;
      end
      MOVE_BACK: begin
        angle_full = -h_ext;
        gain_sel   = kp_back_r;
      end
      // Remaining angle to the right target
      MOVE_RIGHT: begin
        angle_full = tgt_ext - h_ext;
        gain_sel   = kp_turn_r;
      end
      // Remaining angle to the left target, sign flipped to be positive
      MOVE_LEFT: begin
        angle_full = tgt_ext + h_ext;
        gain_sel   = kp_turn_r;
      end
      default: begin
        angle_full = '0;
        gain_sel   = '0;
      end
    endcase
    // Saturate: past the limit any nonzero gain pins the duty the same way
    if (angle_full > ANGF_W'(ANG_LIM)) begin
      angle_sat = ANG_LIM;
    end else if (angle_full < -ANGF_W'(ANG_LIM)) begin
      angle_sat = -ANG_LIM;
    end else begin
      angle_sat = angle_full[ANG_W-1:0];
    end
  end

  ghhd_mul u_mul (
    .clk      (clk),
    .sel_gain (ctl.mul_gain),
    .rate     (rate_r),
    .dt       (dt_r),
    .angle    (angle_sat),
    .gain     (gain_sel),
    .prod_r   (prod_r)
  );

  // --------------------------------------------------------------------------
  // Accumulate step: saturating heading and elapsed time
  // --------------------------------------------------------------------------
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic [ELAP_W:0]            elap_sum;
  logic [ELAP_W-1:0]          elap_nxt;

  always_comb begin
    acc_sum = (ACC_W+1)'(heading_accum_r) + (ACC_W+1)'(prod_r);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nxt = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
    elap_sum = {1'b0, elapsed_r} + (ELAP_W+1)'(dt_r);
    elap_nxt = elap_sum[ELAP_W] ? {ELAP_W{1'b1}} : elap_sum[ELAP_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Result step: scale, stop test and duty clamps
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0]   prod_bias;
  logic signed [PROD_W-1:0]   prod_scaled;
  logic signed [DUTY_W-1:0]   corr;
  logic signed [DUTY_W-1:0]   bl_s, br_s;
  logic                       straight_fin, turn_fin, fin;
  logic [7:0]                 la_nxt, lb_nxt, ra_nxt, rb_nxt, speed;

  always_comb begin
    // Divide by 4096 rounding toward zero
    prod_bias    = prod_r + (prod_r[PROD_W-1] ? PROD_W'(4095) : PROD_W'(0));
    prod_scaled  = prod_bias >>> 12;
    corr         = prod_scaled[DUTY_W-1:0];
    bl_s         = $signed({{(DUTY_W-8){1'b0}}, base_left_r});
    br_s         = $signed({{(DUTY_W-8){1'b0}}, base_right_r});
    straight_fin = {1'b0, elapsed_r} >= {{(ELAP_W+1-DUR_W){1'b0}}, move_duration_r};
    turn_fin     = angle_full <= $signed({{(ANGF_W-MARGIN_W){1'b0}}, margin_r});
    speed        = clamp_duty(corr, turn_min_r);
    la_nxt = '0;
    lb_nxt = '0;
    ra_nxt = '0;
    rb_nxt = '0;
    unique case (active_move_r)
      MOVE_FWD: begin
        fin    = straight_fin;
        lb_nxt = clamp_duty(bl_s + corr, 8'd0);
        ra_nxt = clamp_duty(br_s - corr, 8'd0);
      end
      MOVE_BACK: begin
        fin    = straight_fin;
        la_nxt = clamp_duty(bl_s - corr, 8'd0);
        rb_nxt = clamp_duty(br_s + corr, 8'd0);
      end
      MOVE_RIGHT: begin
        fin    = turn_fin;
        lb_nxt = speed;
        rb_nxt = speed;
      end
      MOVE_LEFT: begin
        fin    = turn_fin;
        la_nxt = speed;
        ra_nxt = speed;
      end
      default: fin = 1'b1;
    endcase
    // Stopped motors once the move ends
    if (fin) begin
      la_nxt = '0;
      lb_nxt = '0;
      ra_nxt = '0;
      rb_nxt = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_fwd_r     <= KP_FWD_RST;
      kp_back_r    <= KP_BACK_RST;
      kp_turn_r    <= KP_TURN_RST;
      base_left_r  <= BASE_LEFT_RST;
      base_right_r <= BASE_RIGHT_RST;
      turn_min_r   <= TURN_MIN_RST;
      margin_r     <= MARGIN_RST;
      gyro_off_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP_FWD:     kp_fwd_r     <= cfg_data[GAIN_W-1:0];
        CFG_KP_BACK:    kp_back_r    <= cfg_data[GAIN_W-1:0];
        CFG_KP_TURN:    kp_turn_r    <= cfg_data[GAIN_W-1:0];
        CFG_BASE_LEFT:  base_left_r  <= cfg_data[7:0];
        CFG_BASE_RIGHT: base_right_r <= cfg_data[7:0];
        CFG_TURN_MIN:   turn_min_r   <= cfg_data[7:0];
        CFG_MARGIN:     margin_r     <= cfg_data[MARGIN_W-1:0];
        CFG_GYRO_OFF:   gyro_off_r   <= $signed(cfg_data[GYRO_W-1:0]);
        default:        gyro_off_r   <= gyro_off_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Move state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_accum_r <= '0;
      elapsed_r       <= '0;
      active_move_r   <= MOVE_FWD;
      turn_target_r   <= '0;
      move_duration_r <= '0;
      finished_r      <= 1'b1;
    end else begin
      if (in_fire && (in_cmd == CMD_START)) begin
        // New move: clear heading and time
        active_move_r   <= move_t'(in_move_kind);
        turn_target_r   <= in_target_deg;
        move_duration_r <= in_duration_ticks;
        heading_accum_r <= '0;
        elapsed_r       <= '0;
        finished_r      <= 1'b0;
      end
      if (ctl.acc_en) begin
        heading_accum_r <= acc_nxt;
        elapsed_r       <= elap_nxt;
      end
      if (ctl.res_en) begin
        finished_r <= fin;
      end
    end
  end

  // Sample operands and result word: payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rate_r <= RATE_W'(in_gyro_rate) - RATE_W'(gyro_off_r);
      dt_r   <= in_dt_ticks;
      // Start and finished-sample words carry all pins low
      la_r   <= '0;
      lb_r   <= '0;
      ra_r   <= '0;
      rb_r   <= '0;
      done_r <= (in_cmd == CMD_SAMPLE);
    end else if (ctl.res_en) begin
      la_r   <= la_nxt;
      lb_r   <= lb_nxt;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
      done_r <= fin;
    end
  end

`ifndef SYNTH
  // Input is never taken while a result word waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // A finished move reports all pins low
  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_move_done) |->
      (out_left_a_pwm == 8'd0 && out_left_b_pwm == 8'd0 &&
       out_right_a_pwm == 8'd0 && out_right_b_pwm == 8'd0))
    else $error("pins driven after move finished");

  // A start word clears heading and arms the move
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_START) |=>
      (heading_accum_r == '0 && elapsed_r == '0 && !finished_r))
    else $error("start word did not clear move state");

  // Only a start word leaves the finished state
  a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && !(in_valid && in_ready && in_cmd == CMD_START)) |=> finished_r)
    else $error("finished state left without start");

  // The sequencer walks straight from the result step to the output
  a_result_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.res_en |=> out_valid)
    else $error("result step not followed by output");
`endif

endmodule : gyro_heading_hold_drive_top
`default_nettype wire
